// ===== src/bclp_pkg.sv =====
// Shared types, constants and helpers for the button click / long-press / repeat block.
package bclp_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IVL_W = 7;
	localparam int unsigned RCNT_W = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd500;

	// Repeat timing
	localparam logic [IVL_W-1:0] START_INTERVAL = 7'd100;
	localparam logic [IVL_W-1:0] MIN_INTERVAL = 7'd50;
	localparam logic [RCNT_W-1:0] REPEATS_BEFORE_SHRINK = 3'd5;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] debounce_ms;
		logic [CFG_DATA_W-1:0] long_press_ms;
	} cfg_t;

	// Event flags, first field in the highest bit
	typedef struct packed {
		logic long_release;
		logic repeat_tick;
		logic long_start;
		logic click;
	} evt_t;

	// floor(iv*9/10) clamped at the minimum; the divide by ten is a multiply by 205 / 2048,
	// exact for products below 1029
	function automatic logic [IVL_W-1:0] shrink_interval(input logic [IVL_W-1:0] iv);
		logic [9:0] p9;
		logic [17:0] q;
		logic [IVL_W-1:0] r;
		p9 = 10'(iv) * 10'd9;
		q = 18'(p9) * 18'd205;
		r = q[17:11];
		if (r < MIN_INTERVAL) begin
			r = MIN_INTERVAL;
		end
		return r;
	endfunction

endpackage

// ===== src/bclp_step.sv =====
// Input register, recognizer state and per-sample event logic.
module bclp_step
	import bclp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_pressed,
	input  logic [31:0] in_now_ms,
	output logic        evt_valid,
	input  logic        evt_ready,
	output evt_t        evt
);

	logic        valid_s1;
	logic        pressed_s1;
	logic [31:0] now_s1;

	logic              held_q;
	logic [31:0]       last_edge_q;
	logic [31:0]       last_repeat_q;
	logic [IVL_W-1:0]  interval_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic              long_seen_q;

	logic [31:0] since_edge;
	logic [31:0] since_repeat;
	logic        settled;
	logic        do_press;
	logic        do_release;
	logic        in_hold;
	logic        fire;
	logic        commit;

	assign in_ready = !valid_s1 || evt_ready;
	assign commit = valid_s1 && evt_ready;

	// Capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pressed_s1 <= in_pressed;
			now_s1 <= in_now_ms;
		end
	end

	// Classify the registered sample
	always_comb begin
		since_edge = now_s1 - last_edge_q;
		since_repeat = now_s1 - last_repeat_q;
		settled = since_edge >= 32'(cfg.debounce_ms);
		do_press = settled && !held_q && pressed_s1;
		do_release = settled && held_q && !pressed_s1;
		in_hold = settled && held_q && pressed_s1 && (since_edge > 32'(cfg.long_press_ms));
		fire = in_hold && (since_repeat > 32'(interval_q));
		evt.click = do_release && (since_edge < 32'(cfg.long_press_ms));
		evt.long_release = do_release && !(since_edge < 32'(cfg.long_press_ms));
		evt.repeat_tick = fire;
		evt.long_start = in_hold && !long_seen_q;
	end

	assign evt_valid = valid_s1;

	// Advance the recognizer state once per delivered sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			last_edge_q <= '0;
			last_repeat_q <= '0;
			interval_q <= START_INTERVAL;
			rcnt_q <= '0;
			long_seen_q <= 1'b0;
		end else if (commit) begin
			if (do_press) begin
				held_q <= 1'b1;
				last_edge_q <= now_s1;
				interval_q <= START_INTERVAL;
				rcnt_q <= '0;
			end
			if (do_release) begin
				held_q <= 1'b0;
				last_edge_q <= now_s1;
				if (evt.long_release) begin
					long_seen_q <= 1'b0;
				end
			end
			if (fire) begin
				last_repeat_q <= now_s1;
				if (rcnt_q >= REPEATS_BEFORE_SHRINK && interval_q > MIN_INTERVAL) begin
					interval_q <= shrink_interval(interval_q);
				end
				if (rcnt_q < REPEATS_BEFORE_SHRINK) begin
					rcnt_q <= rcnt_q + 3'd1;
				end
			end
			if (evt.long_start) begin
				long_seen_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/bclp_out.sv =====
// Result register between the event logic and the output stream.
module bclp_out
	import bclp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       evt_valid,
	output logic       evt_ready,
	input  evt_t       evt,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata
);

	logic valid_q;
	evt_t evt_q;

	assign evt_ready = !valid_q || m_tready;

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evt_ready) begin
			valid_q <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			evt_q <= evt;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {4'b0000, evt_q};

endmodule

// ===== src/button_click_long_press_repeat_top.sv =====
// A beat accepted on s_* passes through the input register, then the result register, and waits on m_* for the sink.
// Throughput: one sample per cycle while m_tready stays high; the state update of one sample sits in a single
// stage between the input register and the result register.
// Reset: arst_n clears both stages, the recognizer state and the registers to
// debounce 50 ms and long press 500 ms; no clearing pass is needed.
module button_click_long_press_repeat_top
	import bclp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,   // [0] pressed, [32:1] now_ms, [39:33] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata    // [0] click, [1] long_start, [2] repeat_tick,
	                                         // [3] long_release, [7:4] zero
);

	cfg_t cfg_q;
	logic evt_valid;
	logic evt_ready;
	evt_t evt;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	bclp_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_pressed (s_tdata[0]),
		.in_now_ms  (s_tdata[32:1]),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt)
	);

	bclp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// A release event never comes with a hold event
	a_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[3]) |-> !m_tdata[1] && !m_tdata[2])
		else $error("release event paired with hold event");

	// Click and long release exclude each other
	a_click_long: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
		else $error("click and long release together");

	// An empty result register always leaves room at the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

	// Pad bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] == 4'b0000)
		else $error("result pad bits set");

endmodule

// ===== tb/sv/tb_button_click_long_press_repeat_top.sv =====
// Testbench for the button click / long-press / auto-repeat recognizer with a self-checking scoreboard.
module tb_button_click_long_press_repeat_top;
	import bclp_pkg::*;

	// Predict the event flags of every accepted sample and match them against result beats
	class click_event_scoreboard;
		cfg_t                  cfg;
		logic                  held;
		logic                  long_seen;
		logic [31:0]           last_edge_ms;
		logic [31:0]           last_rep_ms;
		logic [IVL_W-1:0]      rep_ivl;
		logic [RCNT_W-1:0]     rep_cnt;
		evt_t                  events_due[$];
		int unsigned           errors;
		string                 flag_names[4];

		function new();
			cfg.debounce_ms = DEBOUNCE_RST;
			cfg.long_press_ms = LONG_PRESS_RST;
			held = 1'b0;
			long_seen = 1'b0;
			last_edge_ms = '0;
			last_rep_ms = '0;
			rep_ivl = START_INTERVAL;
			rep_cnt = '0;
			errors = 0;
			flag_names = '{"click", "long_start", "repeat_tick", "long_release"};
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_DEBOUNCE) begin
				cfg.debounce_ms = val;
			end else if (idx == REG_LONG_PRESS) begin
				cfg.long_press_ms = val;
			end
		endfunction

		// Advance the recognizer state by one sample and queue the flags it raises
		function void note_sample(bit pressed, logic [31:0] now);
			evt_t        ev;
			logic [31:0] since_edge;
			int unsigned shrunk;
			ev = '0;
			since_edge = now - last_edge_ms;
			if (since_edge >= cfg.debounce_ms) begin
				if (!held && pressed) begin
					held = 1'b1;
					last_edge_ms = now;
					rep_ivl = START_INTERVAL;
					rep_cnt = '0;
				end else if (held && !pressed) begin
					held = 1'b0;
					if (since_edge < cfg.long_press_ms) begin
						ev.click = 1'b1;
					end else begin
						long_seen = 1'b0;
						ev.long_release = 1'b1;
					end
					last_edge_ms = now;
				end else if (held && pressed && since_edge > cfg.long_press_ms) begin
					if (32'(now - last_rep_ms) > 32'(rep_ivl)) begin
						ev.repeat_tick = 1'b1;
						last_rep_ms = now;
						// shrink the interval once enough repeats have gone by
						if (rep_cnt >= REPEATS_BEFORE_SHRINK && rep_ivl > MIN_INTERVAL) begin
							shrunk = int'(rep_ivl) * 9 / 10;
							if (shrunk < int'(MIN_INTERVAL)) begin
								shrunk = int'(MIN_INTERVAL);
							end
							rep_ivl = IVL_W'(shrunk);
						end
						if (rep_cnt < REPEATS_BEFORE_SHRINK) begin
							rep_cnt = rep_cnt + 1'b1;
						end
					end
					if (!long_seen) begin
						long_seen = 1'b1;
						ev.long_start = 1'b1;
					end
				end
			end
			events_due.push_back(ev);
		endfunction

		function void check_events(logic [7:0] got);
			evt_t     ev;
			logic [3:0] want;
			if (events_due.size() == 0) begin
				$display("%0t: result beat %h with no sample pending", $time, got);
				errors++;
				return;
			end
			ev = events_due.pop_front();
			want = ev;
			for (int i = 0; i < 4; i++) begin
				if (got[i] !== want[i]) begin
					$display("%0t: %s expected %0b got %0b", $time, flag_names[i], want[i],
						got[i]);
					errors++;
				end
			end
			if (got[7:4] !== 4'd0) begin
				$display("%0t: padding expected 0 got %b", $time, got[7:4]);
				errors++;
			end
		endfunction

		function bit idle();
			return events_due.size() == 0;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [39:0]           s_tdata = '0;   // [0] pressed, [32:1] now_ms, [39:33] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // [0] click, [1] long_start, [2] repeat_tick,
	                                       // [3] long_release, [7:4] zero

	click_event_scoreboard sb = new();
	logic [31:0]           t_ms = '0;
	int unsigned           n_sent = 0;
	bit                    calm = 1'b0;
	bit                    hold_req = 1'b0;

	button_click_long_press_repeat_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("tb_button_click_long_press_repeat_top: errors");
		$finish;
	end

	// Sink side: check each result beat, stall in bursts, take one long hold-off on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_events(m_tdata);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one sample beat, maybe after a gap, and hold it until accepted
	task automatic send_sample(input bit pressed, input logic [31:0] now);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, now, pressed};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(pressed, now);
		n_sent++;
	endtask

	// Drain all results, let the pipeline empty, then write both registers
	task automatic apply_cfg(input int unsigned deb, input int unsigned lp);
		s_tvalid <= 1'b0;
		while (!sb.idle()) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_DEBOUNCE;
		cfg_data <= CFG_DATA_W'(deb);
		sb.set_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
		@(posedge clk);
		cfg_idx <= REG_LONG_PRESS;
		cfg_data <= CFG_DATA_W'(lp);
		sb.set_reg(REG_LONG_PRESS, CFG_DATA_W'(lp));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One press: bounce inside the debounce window, hold short, exact or long, then release
	task automatic gesture(input int unsigned deb, input int unsigned lp,
			input int unsigned step_hi);
		int unsigned hold;
		int unsigned elapsed;
		int unsigned d;
		logic [31:0] t0;
		t_ms += deb + $urandom_range(1, step_hi);
		t0 = t_ms;
		send_sample(1'b1, t_ms);
		case ($urandom_range(0, 3))
			0: begin
				hold = (lp > deb) ? $urandom_range(deb, lp - 1) : deb;
			end
			1: begin
				hold = (lp >= deb) ? lp : deb;
			end
			default: begin
				hold = lp + $urandom_range(1, 25 * step_hi);
			end
		endcase
		elapsed = 0;
		d = $urandom_range(1, step_hi);
		while (elapsed + d < hold) begin
			elapsed += d;
			send_sample((elapsed < deb) ? bit'($urandom_range(0, 1)) : 1'b1, t0 + elapsed);
			d = $urandom_range(1, step_hi);
		end
		t_ms = t0 + hold;
		send_sample(1'b0, t_ms);
		repeat ($urandom_range(0, 2)) begin
			t_ms += $urandom_range(1, step_hi);
			send_sample(1'b0, t_ms);
		end
	endtask

	// Random levels with small steps and occasional jumps anywhere on the clock
	task automatic noise(input int unsigned step_hi);
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 3) == 0) begin
				t_ms = $urandom;
			end else begin
				t_ms += $urandom_range(0, step_hi);
			end
			send_sample(bit'($urandom_range(0, 1)), t_ms);
		end
	endtask

	task automatic run_phase(input int unsigned deb, input int unsigned lp,
			input int unsigned step_hi, input int unsigned n, input bit hold_off);
		int unsigned start;
		apply_cfg(deb, lp);
		if (hold_off) begin
			hold_req = 1'b1;
		end
		start = n_sent;
		while (n_sent - start < n) begin
			if ($urandom_range(0, 5) == 0) begin
				noise(step_hi);
			end else begin
				gesture(deb, lp, step_hi);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: debounce, stray edges, click, exact long-press boundary, repeats, wrap
		send_sample(1'b1, 32'd100);
		send_sample(1'b0, 32'd120);
		send_sample(1'b1, 32'd130);
		send_sample(1'b0, 32'd200);
		send_sample(1'b0, 32'd260);
		send_sample(1'b1, 32'd300);
		send_sample(1'b1, 32'd800);
		send_sample(1'b1, 32'd801);
		send_sample(1'b1, 32'd850);
		send_sample(1'b1, 32'd901);
		send_sample(1'b1, 32'd902);
		send_sample(1'b1, 32'd1003);
		send_sample(1'b1, 32'd1104);
		send_sample(1'b1, 32'd1205);
		send_sample(1'b1, 32'd1306);
		send_sample(1'b1, 32'd1397);
		send_sample(1'b1, 32'd1479);
		send_sample(1'b0, 32'd1500);
		send_sample(1'b1, 32'd2000);
		send_sample(1'b0, 32'd2500);
		send_sample(1'b1, 32'hFFFF_FFF0);
		send_sample(1'b0, 32'h0000_0010);
		send_sample(1'b0, 32'h0000_0030);

		// Random gestures over several register settings
		t_ms = $urandom;
		run_phase(5, 20, 120, 90, 1'b0);
		run_phase(0, 0, 60, 50, 1'b0);
		run_phase(65535, 65535, 30000, 30, 1'b0);
		run_phase(50, 500, 40, 100, 1'b1);
		run_phase($urandom_range(0, 200), $urandom_range(0, 1000), $urandom_range(10, 150),
			60, 1'b0);
		calm = 1'b1;
		run_phase(20, 300, 80, 70, 1'b0);

		// Drain and report
		s_tvalid <= 1'b0;
		while (!sb.idle()) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.idle()) begin
			$display("tb_button_click_long_press_repeat_top: clean");
		end else begin
			$display("tb_button_click_long_press_repeat_top: errors");
		end
		$finish;
	end

endmodule
